FILE: rtl/lfmc_pkg.sv
// ----------------------------------------------------------------------------
// lfmc_pkg - shared types and constants of the line follower marker controller
// Holds the operation codes, register indexes, reset values, the
// controller state record and the stepper phase sequence functions.
// ----------------------------------------------------------------------------
package lfmc_pkg;

   // Field widths
   localparam int unsigned OP_W     = 2;
   localparam int unsigned SENSOR_W = 4;
   localparam int unsigned PHASE_W  = 4;
   localparam int unsigned LAMP_W   = 2;
   localparam int unsigned DELAY_W  = 5;
   localparam int unsigned TIMER_W  = 8;
   localparam int unsigned COUNT_W  = 4;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 8;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 24;

   // Operation codes carried on the request tuser
   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE = 2'd0,
      OP_TICK   = 2'd1,
      OP_BUTTON = 2'd2
   } op_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STOP_LIMIT  = 3'd0,
      CSR_TURN_TICKS  = 3'd1,
      CSR_CLEAR_TICKS = 3'd2,
      CSR_BASE_DELAY  = 3'd3,
      CSR_SLOW_EXTRA  = 3'd4
   } csr_index_type;

   // Register reset values
   localparam logic [COUNT_W-1:0] STOP_LIMIT_RST  = 4'd3;
   localparam logic [TIMER_W-1:0] TURN_TICKS_RST  = 8'd25;
   localparam logic [TIMER_W-1:0] CLEAR_TICKS_RST = 8'd180;
   localparam logic [3:0]         BASE_DELAY_RST  = 4'd4;
   localparam logic [3:0]         SLOW_EXTRA_RST  = 4'd2;

   // Lamp codes
   localparam logic [LAMP_W-1:0] CURVE_STRAIGHT = 2'd0;
   localparam logic [LAMP_W-1:0] CURVE_RIGHT    = 2'd1;
   localparam logic [LAMP_W-1:0] CURVE_LEFT     = 2'd2;
   localparam logic [LAMP_W-1:0] MARKER_NONE    = 2'd0;
   localparam logic [LAMP_W-1:0] MARKER_RIGHT   = 2'd1;
   localparam logic [LAMP_W-1:0] MARKER_LEFT    = 2'd2;

   // Forced samples while a turn is held
   localparam logic [SENSOR_W-1:0] HOLD_LEFT_SAMPLE  = 4'h7;
   localparam logic [SENSOR_W-1:0] HOLD_RIGHT_SAMPLE = 4'hE;

   // Controller state
   typedef struct packed {
      logic               drive_mode;
      logic               hold_left;
      logic               hold_right;
      logic               left_pending;
      logic               right_pending;
      logic               square_seen;
      logic [COUNT_W-1:0] square_count;
      logic [TIMER_W-1:0] turn_timer;
      logic [TIMER_W-1:0] clear_timer;
      logic [DELAY_W-1:0] delay_value;
      logic [PHASE_W-1:0] left_phase;
      logic [PHASE_W-1:0] right_phase;
      logic [LAMP_W-1:0]  curve_state;
      logic [LAMP_W-1:0]  marker_state;
   } state_type;

   // Controller state after reset: stopped, cruising delay
   localparam state_type STATE_RST = '{
      drive_mode:    1'b0,
      hold_left:     1'b0,
      hold_right:    1'b0,
      left_pending:  1'b0,
      right_pending: 1'b0,
      square_seen:   1'b0,
      square_count:  '0,
      turn_timer:    '0,
      clear_timer:   '0,
      delay_value:   DELAY_W'(BASE_DELAY_RST),
      left_phase:    '0,
      right_phase:   '0,
      curve_state:   '0,
      marker_state:  '0
   };

   // Left wheel: one half step backward through the phase cycle
   function automatic logic [PHASE_W-1:0] adv_left(input logic [PHASE_W-1:0] p);
      logic [PHASE_W-1:0] r;
      unique case (p)
         4'h9:    r = 4'h8;
         4'h1:    r = 4'h9;
         4'h3:    r = 4'h1;
         4'h2:    r = 4'h3;
         4'h6:    r = 4'h2;
         4'h4:    r = 4'h6;
         4'hC:    r = 4'h4;
         4'h8:    r = 4'hC;
         default: r = 4'hC;
      endcase
      return r;
   endfunction

   // Right wheel: one half step forward through the phase cycle
   function automatic logic [PHASE_W-1:0] adv_right(input logic [PHASE_W-1:0] p);
      logic [PHASE_W-1:0] r;
      unique case (p)
         4'h9:    r = 4'h1;
         4'h1:    r = 4'h3;
         4'h3:    r = 4'h2;
         4'h2:    r = 4'h6;
         4'h6:    r = 4'h4;
         4'h4:    r = 4'hC;
         4'hC:    r = 4'h8;
         4'h8:    r = 4'h9;
         default: r = 4'hC;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/line_follower_marker_controller_core.sv
// ----------------------------------------------------------------------------
// line_follower_marker_controller_core - stepper line follower controller
// Decodes reflectance samples into stepper phases, tracks side markers,
// held turns and stop squares, and reports one status item per request.
// ----------------------------------------------------------------------------
// Every request item (sensor sample, timer tick or start/stop press) gives
// exactly one response item showing the state after that item. Items are
// taken one per clock while the response side keeps up: a request is
// captured in an input register, decoded and applied to the controller
// state combinationally, and the status is held in a response register.
// The state update for one item is the only dependency between items.
// Configuration writes are always accepted and should be made while no item
// is in flight.
module line_follower_marker_controller_core
   import lfmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [3:0] sensor_bits, rest zero
   input  logic [OP_W-1:0]       req_tuser,   // [1:0] operation
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] motor_phase, [9:8] curve_lamp, [11:10] marker_lamp,
   // [16:12] step_delay, [17] driving, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Configuration registers
   logic [COUNT_W-1:0] stop_limit_ff;
   logic [TIMER_W-1:0] turn_ticks_ff;
   logic [TIMER_W-1:0] clear_ticks_ff;
   logic [3:0]         base_delay_ff;
   logic [3:0]         slow_extra_ff;

   // Input stage
   logic                in_valid_ff;
   logic [OP_W-1:0]     in_op_ff;
   logic [SENSOR_W-1:0] in_sensor_ff;

   // State and response stage
   state_type             state_ff, state_in;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  advance;
   logic [DELAY_W-1:0]    slow_delay;

   // Move the input item on when the response register is free or drains
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign slow_delay = DELAY_W'(base_delay_ff) + DELAY_W'(slow_extra_ff);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_limit_ff  <= STOP_LIMIT_RST;
         turn_ticks_ff  <= TURN_TICKS_RST;
         clear_ticks_ff <= CLEAR_TICKS_RST;
         base_delay_ff  <= BASE_DELAY_RST;
         slow_extra_ff  <= SLOW_EXTRA_RST;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_STOP_LIMIT:  stop_limit_ff  <= csr_data[COUNT_W-1:0];
            CSR_TURN_TICKS:  turn_ticks_ff  <= csr_data[TIMER_W-1:0];
            CSR_CLEAR_TICKS: clear_ticks_ff <= csr_data[TIMER_W-1:0];
            CSR_BASE_DELAY:  base_delay_ff  <= csr_data[3:0];
            CSR_SLOW_EXTRA:  slow_extra_ff  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Capture the request item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff     <= req_tuser;
         in_sensor_ff <= req_tdata[SENSOR_W-1:0];
      end
   end

   // Apply the item to the controller state
   always_comb begin
      state_type          st;
      logic [SENSOR_W-1:0] s;
      st = state_ff;
      s  = in_sensor_ff;
      unique case (op_type'(in_op_ff))
         OP_SAMPLE: begin
            if (st.drive_mode) begin
               // held turn overrides the sensors
               if (st.hold_left) begin
                  s = HOLD_LEFT_SAMPLE;
               end else if (st.hold_right) begin
                  s = HOLD_RIGHT_SAMPLE;
               end
               unique case (s)
                  4'hF: begin
                     st.left_phase  = adv_left(st.left_phase);
                     st.right_phase = adv_right(st.right_phase);
                     st.curve_state = CURVE_STRAIGHT;
                     if (st.square_seen) begin
                        st.square_count = st.square_count + COUNT_W'(1);
                        st.square_seen  = 1'b0;
                     end
                  end
                  4'h9, 4'h1, 4'h8: begin
                     st.left_phase  = adv_left(st.left_phase);
                     st.right_phase = adv_right(st.right_phase);
                     st.curve_state = CURVE_STRAIGHT;
                     st.square_seen = 1'b1;
                  end
                  4'hE: begin
                     st.left_phase  = adv_left(st.left_phase);
                     st.curve_state = CURVE_RIGHT;
                  end
                  4'h7: begin
                     st.right_phase = adv_right(st.right_phase);
                     st.curve_state = CURVE_LEFT;
                  end
                  4'hD, 4'h5, 4'h3: begin
                     st.left_phase   = adv_left(st.left_phase);
                     st.right_phase  = adv_right(st.right_phase);
                     st.curve_state  = CURVE_STRAIGHT;
                     st.marker_state = MARKER_RIGHT;
                     if (!st.right_pending) begin
                        st.delay_value   = slow_delay;
                        st.right_pending = 1'b1;
                     end
                  end
                  4'hB, 4'hA, 4'hC: begin
                     st.left_phase   = adv_left(st.left_phase);
                     st.right_phase  = adv_right(st.right_phase);
                     st.curve_state  = CURVE_STRAIGHT;
                     st.marker_state = MARKER_LEFT;
                     if (!st.left_pending) begin
                        st.delay_value  = slow_delay;
                        st.left_pending = 1'b1;
                     end
                  end
                  4'h0: begin
                     // crossing turns a pending turn into a held one
                     if (st.left_pending || st.right_pending) begin
                        if (st.left_pending) begin
                           st.hold_left = 1'b1;
                        end else begin
                           st.hold_right = 1'b1;
                        end
                        st.delay_value   = slow_delay;
                        st.turn_timer    = '0;
                        st.left_pending  = 1'b0;
                        st.right_pending = 1'b0;
                     end
                     st.left_phase  = adv_left(st.left_phase);
                     st.right_phase = adv_right(st.right_phase);
                     st.curve_state = CURVE_STRAIGHT;
                  end
                  default: begin
                     st.left_phase  = adv_left(st.left_phase);
                     st.right_phase = adv_right(st.right_phase);
                     st.curve_state = CURVE_STRAIGHT;
                  end
               endcase
               // halt once enough stop squares are counted
               if (st.square_count >= stop_limit_ff) begin
                  st.drive_mode   = 1'b0;
                  st.square_count = '0;
               end
            end
         end
         OP_TICK: begin
            st.turn_timer  = st.turn_timer + TIMER_W'(1);
            st.clear_timer = st.clear_timer + TIMER_W'(1);
            if (st.turn_timer == turn_ticks_ff) begin
               st.turn_timer   = '0;
               st.hold_left    = 1'b0;
               st.hold_right   = 1'b0;
               st.delay_value  = DELAY_W'(base_delay_ff);
               st.marker_state = MARKER_NONE;
            end
            if (st.clear_timer == clear_ticks_ff) begin
               st.clear_timer   = '0;
               st.square_count  = '0;
               st.left_pending  = 1'b0;
               st.right_pending = 1'b0;
            end
         end
         OP_BUTTON: begin
            st.drive_mode = !st.drive_mode;
         end
         default: ;
      endcase
      state_in    = st;
      rsp_data_in = {6'd0, st.drive_mode, st.delay_value, st.marker_state,
                     st.curve_state, st.right_phase, st.left_phase};
   end

   // Hold the controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RST;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Drive the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

FILE: rtl/lfmc_checker.sv
// ----------------------------------------------------------------------------
// lfmc_checker - port level checks for the line follower marker controller
// Watches the top level ports and flags impossible status or handshake slips.
// ----------------------------------------------------------------------------
module lfmc_checker
   import lfmc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // No response straight after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response holds its item
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Lamps never show the unused code, delay never exceeds both nibbles added
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[9:8] != 2'd3 && rsp_tdata[11:10] != 2'd3
                     && rsp_tdata[16:12] <= 5'd30)
      else $error("response status out of range");

   // An accepted request is followed by a valid response after the input and response registers
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> ##1 rsp_tvalid)
      else $error("accepted item gave no response");

endmodule

bind line_follower_marker_controller_core lfmc_checker u_lfmc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/line_follower_status_checker.sv
// ----------------------------------------------------------------------------
// line_follower_status_checker - status predictor and comparator
// Watches the request, status and register write channels of the line
// follower core, keeps its own copy of the controller state and registers,
// works out the status item that each accepted request should give and
// compares every accepted status item with the oldest one outstanding.
// ----------------------------------------------------------------------------
module line_follower_status_checker
   import lfmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]       req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    mismatch_count,
   output int                    outstanding
);

   typedef struct packed {
      logic [7:0]         motor_phase;
      logic [LAMP_W-1:0]  curve_lamp;
      logic [LAMP_W-1:0]  marker_lamp;
      logic [DELAY_W-1:0] step_delay;
      logic               driving;
   } status_type;

   // Half-step cycle, entry 0 in the lowest nibble: 9,1,3,2,6,4,C,8
   localparam logic [31:0] HALF_STEP = {4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};

   state_type          ctl;
   logic [COUNT_W-1:0] stop_limit_r;
   logic [TIMER_W-1:0] turn_ticks_r;
   logic [TIMER_W-1:0] clear_ticks_r;
   logic [3:0]         base_delay_r;
   logic [3:0]         slow_extra_r;
   status_type         status_q[$];
   status_type         want;
   int                 faults = 0;

   // Step a wheel one place along the cycle; a phase off the cycle restarts at C
   function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] p,
                                                     input logic forward);
      logic [PHASE_W-1:0] r;
      int k;
      r = 4'hC;
      for (k = 0; k < 8; k++) begin
         if (HALF_STEP[k*4 +: 4] == p)
            r = HALF_STEP[((forward ? k + 1 : k + 7) % 8)*4 +: 4];
      end
      return r;
   endfunction

   function automatic void step_both();
      ctl.right_phase = next_phase(ctl.right_phase, 1'b1);
      ctl.left_phase  = next_phase(ctl.left_phase, 1'b0);
   endfunction

   function automatic logic [DELAY_W-1:0] slowed_delay();
      return {1'b0, base_delay_r} + {1'b0, slow_extra_r};
   endfunction

   function automatic void restore_reset();
      stop_limit_r      = STOP_LIMIT_RST;
      turn_ticks_r      = TURN_TICKS_RST;
      clear_ticks_r     = CLEAR_TICKS_RST;
      base_delay_r      = BASE_DELAY_RST;
      slow_extra_r      = SLOW_EXTRA_RST;
      ctl               = '0;
      ctl.delay_value   = {1'b0, BASE_DELAY_RST};
   endfunction

   function automatic void store_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_STOP_LIMIT:  stop_limit_r  = value[COUNT_W-1:0];
         CSR_TURN_TICKS:  turn_ticks_r  = value;
         CSR_CLEAR_TICKS: clear_ticks_r = value;
         CSR_BASE_DELAY:  base_delay_r  = value[3:0];
         CSR_SLOW_EXTRA:  slow_extra_r  = value[3:0];
         default: ;
      endcase
   endfunction

   // Decode one sample while driving
   function automatic void follow_line(input logic [SENSOR_W-1:0] raw);
      logic [SENSOR_W-1:0] s;
      s = raw;
      // a held turn overrides whatever the sensors see
      if (ctl.hold_left)
         s = HOLD_LEFT_SAMPLE;
      else if (ctl.hold_right)
         s = HOLD_RIGHT_SAMPLE;
      case (s)
         4'hF: begin
            step_both();
            ctl.curve_state = CURVE_STRAIGHT;
            if (ctl.square_seen) begin
               ctl.square_count = ctl.square_count + COUNT_W'(1);
               ctl.square_seen  = 1'b0;
            end
         end
         // stop square under the outer sensors
         4'h9, 4'h1, 4'h8: begin
            step_both();
            ctl.curve_state = CURVE_STRAIGHT;
            ctl.square_seen = 1'b1;
         end
         4'hE: begin
            ctl.left_phase  = next_phase(ctl.left_phase, 1'b0);
            ctl.curve_state = CURVE_RIGHT;
         end
         4'h7: begin
            ctl.right_phase = next_phase(ctl.right_phase, 1'b1);
            ctl.curve_state = CURVE_LEFT;
         end
         // right side marker
         4'hD, 4'h5, 4'h3: begin
            step_both();
            ctl.curve_state  = CURVE_STRAIGHT;
            ctl.marker_state = MARKER_RIGHT;
            if (!ctl.right_pending) begin
               ctl.delay_value   = slowed_delay();
               ctl.right_pending = 1'b1;
            end
         end
         // left side marker
         4'hB, 4'hA, 4'hC: begin
            step_both();
            ctl.curve_state  = CURVE_STRAIGHT;
            ctl.marker_state = MARKER_LEFT;
            if (!ctl.left_pending) begin
               ctl.delay_value  = slowed_delay();
               ctl.left_pending = 1'b1;
            end
         end
         // full crossing: a pending turn becomes a held one, left first
         4'h0: begin
            if (ctl.left_pending || ctl.right_pending) begin
               if (ctl.left_pending)
                  ctl.hold_left = 1'b1;
               else
                  ctl.hold_right = 1'b1;
               ctl.delay_value   = slowed_delay();
               ctl.turn_timer    = '0;
               ctl.left_pending  = 1'b0;
               ctl.right_pending = 1'b0;
            end
            step_both();
            ctl.curve_state = CURVE_STRAIGHT;
         end
         default: begin
            step_both();
            ctl.curve_state = CURVE_STRAIGHT;
         end
      endcase
      if (ctl.square_count >= stop_limit_r) begin
         ctl.drive_mode   = 1'b0;
         ctl.square_count = '0;
      end
   endfunction

   // Timer tick: turn expiry first, then the periodic clear
   function automatic void timer_tick();
      ctl.turn_timer  = ctl.turn_timer + TIMER_W'(1);
      ctl.clear_timer = ctl.clear_timer + TIMER_W'(1);
      if (ctl.turn_timer == turn_ticks_r) begin
         ctl.turn_timer   = '0;
         ctl.hold_left    = 1'b0;
         ctl.hold_right   = 1'b0;
         ctl.delay_value  = {1'b0, base_delay_r};
         ctl.marker_state = MARKER_NONE;
      end
      if (ctl.clear_timer == clear_ticks_r) begin
         ctl.clear_timer   = '0;
         ctl.square_count  = '0;
         ctl.left_pending  = 1'b0;
         ctl.right_pending = 1'b0;
      end
   endfunction

   function automatic status_type apply_item(input logic [OP_W-1:0] op,
                                             input logic [SENSOR_W-1:0] sensor);
      status_type st;
      case (op)
         OP_SAMPLE: if (ctl.drive_mode) follow_line(sensor);
         OP_TICK:   timer_tick();
         OP_BUTTON: ctl.drive_mode = ~ctl.drive_mode;
         default: ;
      endcase
      st.motor_phase = {ctl.right_phase, ctl.left_phase};
      st.curve_lamp  = ctl.curve_state;
      st.marker_lamp = ctl.marker_state;
      st.step_delay  = ctl.delay_value;
      st.driving     = ctl.drive_mode;
      return st;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] exp_val,
                                       input logic [7:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
         faults++;
      end
   endfunction

   // Follow every handshake at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         restore_reset();
         status_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            store_register(csr_index, csr_data);
         if (req_tvalid && req_tready)
            status_q.push_back(apply_item(req_tuser, req_tdata[SENSOR_W-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            if (status_q.size() == 0) begin
               $error("status item with nothing outstanding: %h", rsp_tdata);
               faults++;
            end else begin
               want = status_q.pop_front();
               // [7:0] motor_phase, [9:8] curve_lamp, [11:10] marker_lamp,
               // [16:12] step_delay, [17] driving
               check_field("motor_phase", want.motor_phase, rsp_tdata[7:0]);
               check_field("curve_lamp", 8'(want.curve_lamp), 8'(rsp_tdata[9:8]));
               check_field("marker_lamp", 8'(want.marker_lamp), 8'(rsp_tdata[11:10]));
               check_field("step_delay", 8'(want.step_delay), 8'(rsp_tdata[16:12]));
               check_field("driving", 8'(want.driving), 8'(rsp_tdata[17]));
            end
         end
      end
      mismatch_count <= faults;
      outstanding    <= status_q.size();
   end

endmodule

FILE: tb/line_follower_marker_controller_core_tb.sv
// ----------------------------------------------------------------------------
// line_follower_marker_controller_core_tb - top of the line follower bench
// Drives sensor samples, ticks and button presses into the core: a short
// directed sequence first, then random drive scenarios (straight runs, stop
// squares, marker turns, curves, tick bursts, noise) over several register
// settings, with random stalls on both channels. A status checker beside the
// core predicts and compares every status item.
// ----------------------------------------------------------------------------
module line_follower_marker_controller_core_tb
   import lfmc_pkg::*;
();

   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;   // not decoded by the core
   localparam int unsigned     DRIVING_BIT = 17;
   localparam int unsigned     SETTLE_CYCLES = 20;
   localparam int unsigned     TIMEOUT_CYCLES = 600000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;     // [3:0] sensor_bits, rest zero
   logic [OP_W-1:0]       req_tuser = OP_SAMPLE;  // [1:0] operation
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // status fields, see checker
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic                  calm = 1'b0;        // no stalls on either side
   logic                  driving_seen = 1'b0;
   logic [TIMER_W-1:0]    turn_len = TURN_TICKS_RST;
   logic [TIMER_W-1:0]    clear_len = CLEAR_TICKS_RST;
   int                    stall_cycles = 0;
   int unsigned           sent_items = 0;
   int                    mismatches;
   int                    outstanding;

   line_follower_marker_controller_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   line_follower_status_checker i_status_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatches),
      .outstanding    (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the status side in random bursts, never while calm
   always @(posedge clock) begin
      if (calm) begin
         stall_cycles = 0;
         rsp_tready <= 1'b1;
      end else if (stall_cycles > 0) begin
         stall_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 7) == 0)
            stall_cycles = $urandom_range(1, 10);
      end
   end

   // Track the drive mode so stopped stretches get restarted
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         driving_seen <= rsp_tdata[DRIVING_BIT];
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [SENSOR_W-1:0] sensor);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W-SENSOR_W){1'b0}}, sensor};
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   // Hold off until every status item has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings(input logic [3:0] stop_limit, input logic [7:0] turn_ticks,
                                input logic [7:0] clear_ticks, input logic [3:0] base_delay,
                                input logic [3:0] slow_extra);
      write_reg(CSR_STOP_LIMIT, CSR_DATA_W'(stop_limit));
      write_reg(CSR_TURN_TICKS, turn_ticks);
      write_reg(CSR_CLEAR_TICKS, clear_ticks);
      write_reg(CSR_BASE_DELAY, CSR_DATA_W'(base_delay));
      write_reg(CSR_SLOW_EXTRA, CSR_DATA_W'(slow_extra));
      csr_valid <= 1'b0;
      turn_len  = turn_ticks;
      clear_len = clear_ticks;
   endtask

   // Timers mostly short so that expiries and clears happen often
   function automatic logic [7:0] random_ticks();
      return TIMER_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                  : $urandom_range(1, 40));
   endfunction

   function automatic logic [SENSOR_W-1:0] random_sensor();
      return SENSOR_W'($urandom_range(0, 15));
   endfunction

   function automatic logic [3:0] random_nibble(input int unsigned low);
      return 4'($urandom_range(low, 15));
   endfunction

   function automatic logic [SENSOR_W-1:0] marker_code(input logic right_side);
      case ($urandom_range(0, 2))
         0:       return right_side ? 4'hD : 4'hB;
         1:       return right_side ? 4'h5 : 4'hA;
         default: return right_side ? 4'h3 : 4'hC;
      endcase
   endfunction

   function automatic logic [SENSOR_W-1:0] square_code();
      case ($urandom_range(0, 2))
         0:       return 4'h9;
         1:       return 4'h1;
         default: return 4'h8;
      endcase
   endfunction

   // One short piece of track, mostly well formed
   task automatic run_scenario();
      int unsigned kind;
      int unsigned n;
      logic        right_side;
      kind = $urandom_range(0, 99);
      if (!driving_seen && $urandom_range(0, 3) != 0)
         send_item(OP_BUTTON, random_sensor());
      if (kind < 22) begin
         // straight run with the odd stray reading
         repeat ($urandom_range(1, 6))
            send_item(OP_SAMPLE, ($urandom_range(0, 4) == 0) ? random_sensor() : 4'hF);
      end else if (kind < 36) begin
         // stop square, counted on the white behind it
         repeat ($urandom_range(1, 2)) send_item(OP_SAMPLE, square_code());
         repeat ($urandom_range(1, 2)) send_item(OP_SAMPLE, 4'hF);
      end else if (kind < 56) begin
         // marker, crossing, held turn, then ticks, mostly until it expires
         right_side = 1'($urandom_range(0, 1));
         repeat ($urandom_range(1, 3)) send_item(OP_SAMPLE, marker_code(right_side));
         repeat ($urandom_range(0, 3)) send_item(OP_SAMPLE, 4'hF);
         send_item(OP_SAMPLE, 4'h0);
         repeat ($urandom_range(1, 4)) send_item(OP_SAMPLE, random_sensor());
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, turn_len)
                                         : turn_len + $urandom_range(0, 2);
         repeat (n) begin
            send_item(OP_TICK, random_sensor());
            if ($urandom_range(0, 5) == 0)
               send_item(OP_SAMPLE, random_sensor());
         end
      end else if (kind < 66) begin
         repeat ($urandom_range(1, 4))
            send_item(OP_SAMPLE, $urandom_range(0, 1) ? 4'hE : 4'h7);
      end else if (kind < 78) begin
         n = (clear_len < 60 && $urandom_range(0, 2) == 0) ? clear_len : $urandom_range(1, 20);
         repeat (n) send_item(OP_TICK, random_sensor());
      end else if (kind < 90) begin
         repeat ($urandom_range(1, 4))
            send_item(OP_W'($urandom_range(0, 3)), random_sensor());
      end else if (kind < 98) begin
         send_item(OP_BUTTON, random_sensor());
      end else begin
         drain();
      end
   endtask

   task automatic run_phase(input int unsigned budget, input int unsigned calm_tail);
      int unsigned target;
      target = sent_items + budget;
      while (sent_items < target) begin
         if (target - sent_items <= calm_tail)
            calm <= 1'b1;
         else if ($urandom_range(0, 9) == 0)
            calm <= ~calm;
         run_scenario();
      end
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: short timers, stop after two squares
      load_settings(4'd2, 8'd2, 8'd4, 4'd4, 4'd2);
      send_item(OP_RESERVED, 4'hF);   // undecoded operation
      send_item(OP_SAMPLE, 4'h0);     // sample while stopped
      send_item(OP_BUTTON, 4'h0);
      send_item(OP_SAMPLE, 4'hF);     // phases start off the cycle
      send_item(OP_SAMPLE, 4'h9);
      send_item(OP_SAMPLE, 4'hF);     // first square counted
      send_item(OP_SAMPLE, 4'hE);
      send_item(OP_SAMPLE, 4'h7);
      send_item(OP_SAMPLE, 4'h6);
      send_item(OP_SAMPLE, 4'hD);     // right marker
      send_item(OP_SAMPLE, 4'h0);     // crossing: hold right
      send_item(OP_SAMPLE, 4'hB);     // overridden by the held turn
      send_item(OP_TICK, 4'h5);
      send_item(OP_TICK, 4'hA);       // turn expires
      send_item(OP_SAMPLE, 4'hC);     // left marker
      send_item(OP_SAMPLE, 4'h0);     // crossing: hold left
      send_item(OP_SAMPLE, 4'h3);
      send_item(OP_TICK, 4'h0);
      send_item(OP_TICK, 4'hF);       // expiry and clear on one tick
      send_item(OP_SAMPLE, 4'h1);
      send_item(OP_SAMPLE, 4'hF);
      send_item(OP_SAMPLE, 4'h8);
      send_item(OP_SAMPLE, 4'hF);     // stop limit reached
      send_item(OP_SAMPLE, 4'hF);
      send_item(OP_BUTTON, 4'hF);
      drain();

      // Random: extremes first, then mid-range and random settings
      load_settings(4'd1, 8'd1, 8'd1, 4'd0, 4'd0);
      run_phase(200, 0);
      load_settings(4'd15, 8'd255, 8'd255, 4'd15, 4'd15);
      run_phase(250, 0);
      load_settings(4'd2, 8'd6, 8'd40, 4'd7, 4'd3);
      run_phase(250, 0);
      load_settings(random_nibble(1), random_ticks(), random_ticks(),
                    random_nibble(0), random_nibble(0));
      run_phase(250, 0);
      load_settings(random_nibble(1), random_ticks(), random_ticks(),
                    random_nibble(0), random_nibble(0));
      run_phase(300, 150);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 10);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
